[rtl/taje_pkg.sv]
// ============================================================================
// taje_pkg
// Shared types, constants and the control store of the ancestor jump engine.
// ============================================================================
`default_nettype none

package taje_pkg;

    localparam int MAX_NODES = 1024;
    localparam int NODE_W    = $clog2(MAX_NODES);
    localparam int CNT_W     = $clog2(MAX_NODES + 1);
    localparam int DEPTH_W   = 16;
    localparam int PATH_W    = 11;
    localparam int ACT_W     = 2;
    localparam int PC_W      = 5;

    localparam logic [ACT_W-1:0] ACT_ADD  = 2'd0;
    localparam logic [ACT_W-1:0] ACT_LCA  = 2'd1;
    localparam logic [ACT_W-1:0] ACT_KTH  = 2'd2;
    localparam logic [ACT_W-1:0] ACT_NONE = 2'd3;

    typedef logic [NODE_W-1:0]  node_t;
    typedef logic [DEPTH_W-1:0] depth_t;
    typedef logic [PC_W-1:0]    pc_t;

    typedef struct packed {
        depth_t depth;
        node_t  parent;
        node_t  jump;
    } node_rec_t;

    typedef enum logic [3:0] {
        C_NEVER,
        C_ALWAYS,
        C_ROOT,
        C_KOK,
        C_CLIMB_END,
        C_JDEEP,
        C_IS_LCA,
        C_UEQV,
        C_LCA_END
    } cond_t;

    typedef enum logic [3:0] {
        RD_NONE,
        RD_A,
        RD_B,
        RD_P,
        RD_RDJ,
        RD_URJ,
        RD_URP,
        RD_U,
        RD_UNEXT,
        RD_VNEXT
    } rd_sel_t;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LD_UR,
        OP_LD_VR,
        OP_WR_ADD,
        OP_WR_ROOT,
        OP_LD_UA,
        OP_LD_VB,
        OP_SWAP,
        OP_TGT_KTH,
        OP_TGT_LCA,
        OP_CLIMB_JUMP,
        OP_CLIMB_PAR,
        OP_C_U,
        OP_C_UP,
        OP_ADV_U,
        OP_ADV_V
    } op_t;

    typedef enum logic [2:0] {
        F_NONE,
        F_ADD,
        F_KBAD,
        F_BAD,
        F_KTH,
        F_LCA
    } fin_t;

    typedef struct packed {
        cond_t   cond;
        pc_t     target;
        rd_sel_t rd;
        op_t     op;
        fin_t    fin;
    } ctrl_word_t;

    localparam pc_t PC_ADD0 = 5'd0;
    localparam pc_t PC_ADD1 = 5'd1;
    localparam pc_t PC_ADD2 = 5'd2;
    localparam pc_t PC_ADD3 = 5'd3;
    localparam pc_t PC_ADDR = 5'd4;
    localparam pc_t PC_KTH0 = 5'd5;
    localparam pc_t PC_KTH1 = 5'd6;
    localparam pc_t PC_KTH2 = 5'd7;
    localparam pc_t PC_KBAD = 5'd8;
    localparam pc_t PC_BAD  = 5'd9;
    localparam pc_t PC_LCA0 = 5'd10;
    localparam pc_t PC_LCA1 = 5'd11;
    localparam pc_t PC_LCA2 = 5'd12;
    localparam pc_t PC_LCA3 = 5'd13;
    localparam pc_t PC_LCA4 = 5'd14;
    localparam pc_t PC_CL0  = 5'd15;
    localparam pc_t PC_CL1  = 5'd16;
    localparam pc_t PC_CL2  = 5'd17;
    localparam pc_t PC_CRET = 5'd18;
    localparam pc_t PC_KFIN = 5'd19;
    localparam pc_t PC_LC0  = 5'd20;
    localparam pc_t PC_LP0  = 5'd21;
    localparam pc_t PC_LP1  = 5'd22;
    localparam pc_t PC_LP2  = 5'd23;
    localparam pc_t PC_LX   = 5'd24;
    localparam pc_t PC_LF0  = 5'd25;

    function automatic ctrl_word_t step(cond_t c, pc_t t, rd_sel_t r, op_t o, fin_t f);
        ctrl_word_t w;
        w.cond   = c;
        w.target = t;
        w.rd     = r;
        w.op     = o;
        w.fin    = f;
        return w;
    endfunction

    function automatic ctrl_word_t ucode(pc_t pc);
        ctrl_word_t w;
        unique case (pc)
            PC_ADD0: w = step(C_ROOT,      PC_ADDR, RD_P,     OP_NONE,       F_NONE);
            PC_ADD1: w = step(C_NEVER,     PC_ADD0, RD_RDJ,   OP_LD_UR,      F_NONE);
            PC_ADD2: w = step(C_NEVER,     PC_ADD0, RD_RDJ,   OP_LD_VR,      F_NONE);
            PC_ADD3: w = step(C_NEVER,     PC_ADD0, RD_NONE,  OP_WR_ADD,     F_ADD);
            PC_ADDR: w = step(C_NEVER,     PC_ADD0, RD_NONE,  OP_WR_ROOT,    F_ADD);
            PC_KTH0: w = step(C_NEVER,     PC_ADD0, RD_A,     OP_NONE,       F_NONE);
            PC_KTH1: w = step(C_NEVER,     PC_ADD0, RD_NONE,  OP_LD_UA,      F_NONE);
            PC_KTH2: w = step(C_KOK,       PC_CL0,  RD_NONE,  OP_TGT_KTH,    F_NONE);
            PC_KBAD: w = step(C_NEVER,     PC_ADD0, RD_NONE,  OP_NONE,       F_KBAD);
            PC_BAD:  w = step(C_NEVER,     PC_ADD0, RD_NONE,  OP_NONE,       F_BAD);
            PC_LCA0: w = step(C_NEVER,     PC_ADD0, RD_A,     OP_NONE,       F_NONE);
            PC_LCA1: w = step(C_NEVER,     PC_ADD0, RD_B,     OP_LD_UA,      F_NONE);
            PC_LCA2: w = step(C_NEVER,     PC_ADD0, RD_NONE,  OP_LD_VB,      F_NONE);
            PC_LCA3: w = step(C_NEVER,     PC_ADD0, RD_NONE,  OP_SWAP,       F_NONE);
            PC_LCA4: w = step(C_NEVER,     PC_ADD0, RD_NONE,  OP_TGT_LCA,    F_NONE);
            PC_CL0:  w = step(C_CLIMB_END, PC_CRET, RD_URJ,   OP_NONE,       F_NONE);
            PC_CL1:  w = step(C_JDEEP,     PC_CL0,  RD_URP,   OP_CLIMB_JUMP, F_NONE);
            PC_CL2:  w = step(C_ALWAYS,    PC_CL0,  RD_NONE,  OP_CLIMB_PAR,  F_NONE);
            PC_CRET: w = step(C_IS_LCA,    PC_LC0,  RD_NONE,  OP_NONE,       F_NONE);
            PC_KFIN: w = step(C_NEVER,     PC_ADD0, RD_NONE,  OP_NONE,       F_KTH);
            PC_LC0:  w = step(C_UEQV,      PC_LF0,  RD_U,     OP_C_U,        F_NONE);
            PC_LP0:  w = step(C_LCA_END,   PC_LX,   RD_UNEXT, OP_NONE,       F_NONE);
            PC_LP1:  w = step(C_NEVER,     PC_ADD0, RD_VNEXT, OP_ADV_U,      F_NONE);
            PC_LP2:  w = step(C_ALWAYS,    PC_LP0,  RD_NONE,  OP_ADV_V,      F_NONE);
            PC_LX:   w = step(C_NEVER,     PC_ADD0, RD_URP,   OP_C_UP,       F_NONE);
            PC_LF0:  w = step(C_NEVER,     PC_ADD0, RD_NONE,  OP_NONE,       F_LCA);
            default: w = step(C_NEVER,     PC_ADD0, RD_NONE,  OP_NONE,       F_BAD);
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

[rtl/tree_ancestor_jump_engine.sv]
// ============================================================================
// tree_ancestor_jump_engine
// Rooted tree store with skew-binary jump pointers and ancestor queries.
// ============================================================================
// Usage:
//   A request is taken on a rising edge with start high and busy low; the
//   fields action, node_a, parent_node, node_b and steps are sampled then.
//   Action add inserts node_a below parent_node (a root when both are equal),
//   action lca returns the lowest common ancestor of node_a and node_b with
//   the path length, action kth returns the ancestor steps levels above
//   node_a. Each request gives one result, shown for one cycle with done.
//   An add of a root writes its record at once; other adds first read the
//   parent record and its jump chain. A kth that reaches past the root and
//   an unused action end with an invalid result and no climb. An lca climbs
//   the deeper node to the other's depth and, unless it lands on the other,
//   steps both nodes up in pairs. Each climb step is bound by the single
//   read port of the node record memory, one record read per cycle. A query
//   follows jump pointers, so the step count is about logarithmic in depth.
//   busy is high from acceptance until the result cycle; a new request may
//   be taken in the cycle that shows done. The receiver cannot stall.
//   Reset clears the sequencer and the result strobe; node records hold
//   garbage until written and need no clearing pass.
// ============================================================================
`default_nettype none

module tree_ancestor_jump_engine (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      start,
    output logic                           busy,
    input  wire logic [taje_pkg::ACT_W-1:0]  action,
    input  wire logic [taje_pkg::NODE_W-1:0] node_a,
    input  wire logic [taje_pkg::NODE_W-1:0] parent_node,
    input  wire logic [taje_pkg::NODE_W-1:0] node_b,
    input  wire logic [taje_pkg::NODE_W-1:0] steps,
    output logic                           done,
    output logic [taje_pkg::NODE_W-1:0]      result_node,
    output logic                           result_valid,
    output logic [taje_pkg::PATH_W-1:0]      path_length
);
    import taje_pkg::*;

    localparam logic [CNT_W-1:0] CNT_LIMIT = CNT_W'(MAX_NODES);

    node_rec_t mem [MAX_NODES];
    node_rec_t rd_q;

    logic                busy_reg;
    logic                done_reg;
    pc_t                 pc_reg;
    node_t               res_node_reg;
    logic                res_valid_reg;
    logic [PATH_W-1:0]   path_reg;

    logic [ACT_W-1:0]    act_reg;
    node_t               a_reg, p_reg, b_reg;
    node_t               k_reg;
    node_t               u_reg, v_reg, c_reg;
    node_rec_t           ur_reg, vr_reg;
    depth_t              tgt_reg;
    logic [DEPTH_W:0]    sum_reg;
    logic [CNT_W-1:0]    cnt_reg;
    logic                flag_reg;

    ctrl_word_t          cw;
    logic                accept;
    logic                take;
    pc_t                 pc_next;
    node_t               rd_addr;
    logic                wr_en;
    node_t               wr_addr;
    node_rec_t           wr_data;
    logic [DEPTH_W:0]    add_lhs;
    logic [DEPTH_W:0]    add_rhs;
    logic [DEPTH_W:0]    twice_c;
    logic [DEPTH_W:0]    path_full;
    logic                jump_differs;
    pc_t                 entry;

    assign accept = start && !busy_reg;
    assign cw     = ucode(pc_reg);
    assign jump_differs = ur_reg.jump != vr_reg.jump;

    always_comb
    begin
        unique case (action)
            ACT_ADD:  entry = PC_ADD0;
            ACT_LCA:  entry = PC_LCA0;
            ACT_KTH:  entry = PC_KTH0;
            ACT_NONE: entry = PC_BAD;
        endcase
    end

    always_comb
    begin
        unique case (cw.cond)
            C_NEVER:     take = 1'b0;
            C_ALWAYS:    take = 1'b1;
            C_ROOT:      take = a_reg == p_reg;
            C_KOK:       take = {{(DEPTH_W-NODE_W){1'b0}}, k_reg} <= ur_reg.depth;
            C_CLIMB_END: take = !((ur_reg.depth > tgt_reg) && (cnt_reg < CNT_LIMIT));
            C_JDEEP:     take = rd_q.depth >= tgt_reg;
            C_IS_LCA:    take = act_reg == ACT_LCA;
            C_UEQV:      take = u_reg == v_reg;
            C_LCA_END:   take = !((ur_reg.parent != vr_reg.parent) && (cnt_reg < CNT_LIMIT));
            default:     take = 1'b0;
        endcase
        pc_next = take ? cw.target : pc_reg + pc_t'(1);
    end

    always_comb
    begin
        unique case (cw.rd)
            RD_NONE:  rd_addr = a_reg;
            RD_A:     rd_addr = a_reg;
            RD_B:     rd_addr = b_reg;
            RD_P:     rd_addr = p_reg;
            RD_RDJ:   rd_addr = rd_q.jump;
            RD_URJ:   rd_addr = ur_reg.jump;
            RD_URP:   rd_addr = ur_reg.parent;
            RD_U:     rd_addr = u_reg;
            RD_UNEXT: rd_addr = jump_differs ? ur_reg.jump : ur_reg.parent;
            RD_VNEXT: rd_addr = jump_differs ? vr_reg.jump : vr_reg.parent;
            default:  rd_addr = a_reg;
        endcase
    end

    // ur holds the parent record, vr the j1 record, rd_q the j2 record
    assign add_lhs = {1'b0, ur_reg.depth} + {1'b0, rd_q.depth};
    assign add_rhs = {vr_reg.depth, 1'b0};

    always_comb
    begin
        wr_en   = busy_reg && ((cw.op == OP_WR_ADD) || (cw.op == OP_WR_ROOT));
        wr_addr = a_reg;
        if (cw.op == OP_WR_ROOT)
        begin
            wr_data.depth  = '0;
            wr_data.parent = a_reg;
            wr_data.jump   = a_reg;
        end
        else
        begin
            wr_data.depth  = ur_reg.depth + depth_t'(1);
            wr_data.parent = p_reg;
            wr_data.jump   = (add_lhs == add_rhs) ? vr_reg.jump : p_reg;
        end
    end

    assign twice_c   = {rd_q.depth, 1'b0};
    assign path_full = sum_reg - twice_c;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_q <= mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            act_reg <= action;
            a_reg   <= node_a;
            p_reg   <= parent_node;
            b_reg   <= node_b;
            k_reg   <= steps;
        end
        else if (busy_reg)
        begin
            unique case (cw.op)
                OP_NONE, OP_WR_ADD, OP_WR_ROOT: ;
                OP_LD_UR: ur_reg <= rd_q;
                OP_LD_VR: vr_reg <= rd_q;
                OP_LD_UA:
                begin
                    ur_reg <= rd_q;
                    u_reg  <= a_reg;
                end
                OP_LD_VB:
                begin
                    vr_reg <= rd_q;
                    v_reg  <= b_reg;
                end
                OP_SWAP:
                begin
                    if (ur_reg.depth < vr_reg.depth)
                    begin
                        ur_reg <= vr_reg;
                        vr_reg <= ur_reg;
                        u_reg  <= v_reg;
                        v_reg  <= u_reg;
                    end
                end
                OP_TGT_KTH:
                begin
                    tgt_reg <= ur_reg.depth - {{(DEPTH_W-NODE_W){1'b0}}, k_reg};
                    cnt_reg <= '0;
                end
                OP_TGT_LCA:
                begin
                    tgt_reg <= vr_reg.depth;
                    sum_reg <= {1'b0, ur_reg.depth} + {1'b0, vr_reg.depth};
                    cnt_reg <= '0;
                end
                OP_CLIMB_JUMP:
                begin
                    if (rd_q.depth >= tgt_reg)
                    begin
                        u_reg   <= ur_reg.jump;
                        ur_reg  <= rd_q;
                        cnt_reg <= cnt_reg + CNT_W'(1);
                    end
                end
                OP_CLIMB_PAR:
                begin
                    u_reg   <= ur_reg.parent;
                    ur_reg  <= rd_q;
                    cnt_reg <= cnt_reg + CNT_W'(1);
                end
                OP_C_U:
                begin
                    c_reg   <= u_reg;
                    cnt_reg <= '0;
                end
                OP_C_UP: c_reg <= ur_reg.parent;
                OP_ADV_U:
                begin
                    flag_reg <= jump_differs;
                    ur_reg   <= rd_q;
                    u_reg    <= jump_differs ? ur_reg.jump : ur_reg.parent;
                end
                OP_ADV_V:
                begin
                    vr_reg  <= rd_q;
                    v_reg   <= flag_reg ? vr_reg.jump : vr_reg.parent;
                    cnt_reg <= cnt_reg + CNT_W'(1);
                end
                default: ;
            endcase
        end
    end

    // flag_reg must reflect the pair compared when u's read was issued
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            done_reg      <= 1'b0;
            pc_reg        <= PC_ADD0;
            res_node_reg  <= '0;
            res_valid_reg <= 1'b0;
            path_reg      <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (accept)
            begin
                busy_reg <= 1'b1;
                pc_reg   <= entry;
            end
            else if (busy_reg)
            begin
                pc_reg <= pc_next;
                if (cw.fin != F_NONE)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                unique case (cw.fin)
                    F_NONE: ;
                    F_ADD:
                    begin
                        res_node_reg  <= a_reg;
                        res_valid_reg <= 1'b1;
                        path_reg      <= '0;
                    end
                    F_KBAD, F_BAD:
                    begin
                        res_node_reg  <= '0;
                        res_valid_reg <= 1'b0;
                        path_reg      <= '0;
                    end
                    F_KTH:
                    begin
                        res_node_reg  <= u_reg;
                        res_valid_reg <= 1'b1;
                        path_reg      <= '0;
                    end
                    F_LCA:
                    begin
                        res_node_reg  <= c_reg;
                        res_valid_reg <= 1'b1;
                        path_reg      <= path_full[PATH_W-1:0];
                    end
                    default: ;
                endcase
            end
        end
    end

    assign busy         = busy_reg;
    assign done         = done_reg;
    assign result_node  = res_node_reg;
    assign result_valid = res_valid_reg;
    assign path_length  = path_reg;

endmodule

`default_nettype wire

[rtl/taje_checker.sv]
// ============================================================================
// taje_checker
// Port-level checks of the ancestor jump engine's request and result timing and of invalid results.
// ============================================================================
`default_nettype none

module taje_checker (
    input wire logic                        clk,
    input wire logic                        rst_n,
    input wire logic                        start,
    input wire logic                        busy,
    input wire logic                        done,
    input wire logic [taje_pkg::NODE_W-1:0] result_node,
    input wire logic                        result_valid,
    input wire logic [taje_pkg::PATH_W-1:0] path_length
);
    import taje_pkg::*;

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("request taken without raising busy");

    a_done_frees: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy && $past(busy))
        else $error("result shown outside the end of a request");

    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe held for more than one cycle");

    a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done && !result_valid |-> result_node == '0 && path_length == '0)
        else $error("invalid result carries nonzero fields");

endmodule

bind tree_ancestor_jump_engine taje_checker u_taje_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .done         (done),
    .result_node  (result_node),
    .result_valid (result_valid),
    .path_length  (path_length)
);

`default_nettype wire

[dv/tb_top.sv]
// ============================================================================
// tb_top
// Self-checking bench for the tree ancestor jump engine. Builds trees from
// shuffled node numbers, mixes in lca, kth and unused actions, and compares
// every result against an in-bench model of the depth, parent and jump
// tables. Covers root adds, leaf moves, out-of-depth kth requests, queries
// across separate trees, and a parent cycle that runs into the climb bound.
// ============================================================================
`default_nettype none

module tb_top;

    timeunit 1ns;
    timeprecision 1ps;

    import taje_pkg::*;

    localparam int unsigned ITEM_TARGET = 1900;
    localparam int unsigned STALL_LIMIT = 40000;
    localparam int unsigned DRAIN_CYCLES = 16;

    typedef logic [NODE_W-1:0] count_t;

    typedef struct {
        node_t             anc;
        logic              ok;
        logic [PATH_W-1:0] span;
    } answer_t;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              start = 1'b0;
    logic [ACT_W-1:0]  action = ACT_ADD;
    node_t             node_a = '0;
    node_t             parent_node = '0;
    node_t             node_b = '0;
    count_t            steps = '0;
    logic              busy;
    logic              done;
    node_t             result_node;
    logic              result_valid;
    logic [PATH_W-1:0] path_length;

    depth_t      tree_depth  [MAX_NODES];
    node_t       tree_parent [MAX_NODES];
    node_t       tree_jump   [MAX_NODES];

    answer_t     pending_answers [$];
    node_t       node_pool [MAX_NODES];
    node_t       members [$];
    int unsigned kids [MAX_NODES];

    bit          quiet_stretch;
    int unsigned requests_sent;
    int unsigned answers_checked;
    int unsigned error_count;
    int unsigned adds_sent;
    int unsigned lca_sent;
    int unsigned kth_sent;
    int unsigned kth_too_deep;
    int unsigned unused_sent;
    int unsigned deepest;
    int unsigned stall_cycles;

    tree_ancestor_jump_engine dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .action       (action),
        .node_a       (node_a),
        .parent_node  (parent_node),
        .node_b       (node_b),
        .steps        (steps),
        .done         (done),
        .result_node  (result_node),
        .result_valid (result_valid),
        .path_length  (path_length)
    );

    initial
    begin
        forever #2 clk = ~clk;
    end

    function automatic node_t any_node();
        return node_t'($urandom_range(MAX_NODES - 1, 0));
    endfunction

    function automatic node_t climb_toward(node_t u, int unsigned goal);
        node_t       j;
        int unsigned guard;
        guard = 0;
        while (tree_depth[u] > goal && guard < MAX_NODES)
        begin
            j = tree_jump[u];
            if (tree_depth[j] >= goal)
                u = j;
            else
                u = tree_parent[u];
            guard++;
        end
        return u;
    endfunction

    function automatic node_t lowest_common(node_t u, node_t v);
        node_t       t;
        int unsigned guard;
        if (tree_depth[u] < tree_depth[v])
        begin
            t = u;
            u = v;
            v = t;
        end
        u = climb_toward(u, tree_depth[v]);
        if (u == v)
            return u;
        guard = 0;
        while (tree_parent[u] != tree_parent[v] && guard < MAX_NODES)
        begin
            if (tree_jump[u] != tree_jump[v])
            begin
                u = tree_jump[u];
                v = tree_jump[v];
            end
            else
            begin
                u = tree_parent[u];
                v = tree_parent[v];
            end
            guard++;
        end
        return tree_parent[u];
    endfunction

    function automatic answer_t resolve_request(logic [ACT_W-1:0] act, node_t a, node_t p,
                                                node_t b, count_t k);
        answer_t     ans;
        node_t       j1;
        node_t       j2;
        node_t       c;
        int unsigned lhs;
        int unsigned rhs;
        int unsigned span;
        ans.anc  = '0;
        ans.ok   = 1'b0;
        ans.span = '0;
        case (act)
            ACT_ADD:
            begin
                if (a == p)
                begin
                    tree_depth[a]  = '0;
                    tree_parent[a] = a;
                    tree_jump[a]   = a;
                end
                else
                begin
                    j1  = tree_jump[p];
                    j2  = tree_jump[j1];
                    lhs = tree_depth[p] + tree_depth[j2];
                    rhs = 2 * tree_depth[j1];
                    tree_depth[a]  = tree_depth[p] + 1'b1;
                    tree_parent[a] = p;
                    tree_jump[a]   = (lhs == rhs) ? j2 : p;
                end
                ans.anc = a;
                ans.ok  = 1'b1;
            end
            ACT_LCA:
            begin
                c    = lowest_common(a, b);
                span = tree_depth[a] + tree_depth[b] - 2 * tree_depth[c];
                ans.anc  = c;
                ans.ok   = 1'b1;
                ans.span = span[PATH_W-1:0];
            end
            ACT_KTH:
            begin
                if (k <= tree_depth[a])
                begin
                    ans.anc = climb_toward(a, tree_depth[a] - k);
                    ans.ok  = 1'b1;
                end
            end
            default:
            begin
            end
        endcase
        return ans;
    endfunction

    function automatic int unsigned pick_gap();
        int unsigned roll;
        if (quiet_stretch)
            return 0;
        roll = $urandom_range(99, 0);
        if (roll < 55)
            return 0;
        if (roll < 85)
            return $urandom_range(3, 1);
        if (roll < 97)
            return $urandom_range(15, 4);
        return $urandom_range(60, 16);
    endfunction

    task automatic send_request(input logic [ACT_W-1:0] act, input node_t a, input node_t p,
                                input node_t b, input count_t k);
        int unsigned gap;
        answer_t     ans;
        gap = pick_gap();
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start       <= 1'b1;
        action      <= act;
        node_a      <= a;
        parent_node <= p;
        node_b      <= b;
        steps       <= k;
        do
            @(posedge clk);
        while (busy);
        ans = resolve_request(act, a, p, b, k);
        pending_answers = {pending_answers, ans};
        requests_sent++;
        case (act)
            ACT_ADD:
            begin
                adds_sent++;
                if (tree_depth[a] > deepest)
                    deepest = tree_depth[a];
            end
            ACT_LCA: lca_sent++;
            ACT_KTH:
            begin
                kth_sent++;
                if (!ans.ok)
                    kth_too_deep++;
            end
            default: unused_sent++;
        endcase
    endtask

    // hold the sender until every outstanding request has answered
    task automatic wait_drained();
        start <= 1'b0;
        do
            @(posedge clk);
        while (pending_answers.size() != 0);
    endtask

    task automatic note_error(input string msg);
        error_count++;
        if (error_count <= 10)
            $display("%s", msg);
    endtask

    task automatic shuffle_pool();
        int unsigned i;
        int unsigned j;
        node_t       t;
        for (i = 0; i < MAX_NODES; i++)
            node_pool[i] = node_t'(i);
        for (i = MAX_NODES - 1; i > 0; i--)
        begin
            j = $urandom_range(i, 0);
            t = node_pool[i];
            node_pool[i] = node_pool[j];
            node_pool[j] = t;
        end
    endtask

    task automatic random_query(input bit allow_move);
        node_t       u;
        node_t       v;
        node_t       up;
        int unsigned roll;
        int unsigned d;
        roll = $urandom_range(99, 0);
        u = members[$urandom_range(members.size() - 1, 0)];
        if (roll < 6)
            send_request(ACT_NONE, any_node(), any_node(), any_node(), any_node());
        else if (roll < 11)
        begin
            // move a leaf under another member; no cycle can form
            up = members[$urandom_range(members.size() - 1, 0)];
            if (allow_move && kids[u] == 0 && u != members[0] && up != u)
            begin
                kids[tree_parent[u]]--;
                kids[up]++;
                send_request(ACT_ADD, u, up, any_node(), any_node());
            end
        end
        else if (roll < 55)
        begin
            v = (roll < 15) ? u : members[$urandom_range(members.size() - 1, 0)];
            send_request(ACT_LCA, u, any_node(), v, any_node());
        end
        else
        begin
            d = (tree_depth[u] > MAX_NODES - 1) ? MAX_NODES - 1 : tree_depth[u];
            if ($urandom_range(3, 0) == 0)
                send_request(ACT_KTH, u, any_node(), any_node(), any_node());
            else
                send_request(ACT_KTH, u, any_node(), any_node(), count_t'($urandom_range(d, 0)));
        end
    endtask

    task automatic run_episode(input int unsigned size, input int unsigned chain_pct,
                               input int unsigned query_pct, input int unsigned tail_queries);
        node_t       fresh;
        node_t       up;
        int unsigned i;
        shuffle_pool();
        members.delete();
        quiet_stretch = ($urandom_range(3, 0) == 0);
        fresh = node_pool[0];
        send_request(ACT_ADD, fresh, fresh, any_node(), any_node());
        kids[fresh] = 0;
        members = {members, fresh};
        for (i = 1; i < size; i++)
        begin
            fresh = node_pool[i];
            if ($urandom_range(99, 0) < chain_pct)
                up = members[members.size() - 1];
            else
                up = members[$urandom_range(members.size() - 1, 0)];
            send_request(ACT_ADD, fresh, up, any_node(), any_node());
            kids[fresh] = 0;
            kids[up]++;
            members = {members, fresh};
            if ($urandom_range(99, 0) < query_pct)
                random_query(chain_pct < 100);
        end
        repeat (tail_queries) random_query(1'b1);
    endtask

    task automatic test_directed_basics();
        quiet_stretch = 1'b0;
        send_request(ACT_ADD, 10'd0, 10'd0, '0, '0);
        send_request(ACT_ADD, 10'd1023, 10'd0, '1, '1);
        send_request(ACT_ADD, 10'd512, 10'd1023, '0, '0);
        send_request(ACT_KTH, 10'd512, '0, '0, 10'd0);
        send_request(ACT_KTH, 10'd512, '0, '0, 10'd2);
        send_request(ACT_KTH, 10'd512, '0, '0, 10'd3);
        send_request(ACT_KTH, 10'd512, '1, '1, 10'd1023);
        send_request(ACT_LCA, 10'd512, '0, 10'd1023, '0);
        send_request(ACT_LCA, 10'd1023, '1, 10'd512, '1);
        send_request(ACT_LCA, 10'd512, '0, 10'd512, '0);
        send_request(ACT_NONE, '1, '1, '1, '1);
        send_request(ACT_NONE, '0, '0, '0, '0);
        send_request(ACT_ADD, 10'd341, 10'd0, '0, '0);
        send_request(ACT_LCA, 10'd341, '0, 10'd512, '0);
        // move a leaf, then turn another into a separate root
        send_request(ACT_ADD, 10'd512, 10'd341, '0, '0);
        send_request(ACT_KTH, 10'd512, '0, '0, 10'd1);
        send_request(ACT_ADD, 10'd1023, 10'd1023, '0, '0);
        send_request(ACT_LCA, 10'd1023, '0, 10'd341, '0);
        wait_drained();
    endtask

    task automatic test_cycle_bound();
        send_request(ACT_ADD, 10'd5, 10'd5, '0, '0);
        send_request(ACT_ADD, 10'd6, 10'd5, '0, '0);
        send_request(ACT_ADD, 10'd5, 10'd6, '0, '0);
        send_request(ACT_KTH, 10'd5, '0, '0, 10'd2);
        send_request(ACT_KTH, 10'd6, '0, '0, 10'd1);
        send_request(ACT_LCA, 10'd5, '0, 10'd6, '0);
        wait_drained();
    endtask

    task automatic test_deep_chain();
        run_episode(MAX_NODES, 100, 8, 60);
        wait_drained();
    endtask

    task automatic test_random_forests();
        while (requests_sent < ITEM_TARGET)
        begin
            if ($urandom_range(9, 0) == 0)
                run_episode($urandom_range(300, 100), $urandom_range(90, 0),
                            $urandom_range(40, 20), $urandom_range(30, 10));
            else
                run_episode($urandom_range(60, 4), $urandom_range(90, 0),
                            $urandom_range(60, 30), $urandom_range(30, 10));
            if ($urandom_range(1, 0) == 0)
                wait_drained();
        end
    endtask

    always @(posedge clk)
    begin
        answer_t want;
        if (rst_n && done)
        begin
            if (pending_answers.size() == 0)
                note_error($sformatf("unexpected result: node %0d valid %0d path %0d",
                                     result_node, result_valid, path_length));
            else
            begin
                want = pending_answers.pop_front();
                answers_checked++;
                if (result_node !== want.anc || result_valid !== want.ok ||
                    path_length !== want.span)
                    note_error($sformatf(
                        "mismatch: got node %0d valid %0d path %0d, want %0d %0d %0d",
                        result_node, result_valid, path_length,
                        want.anc, want.ok, want.span));
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || done || (start && !busy))
            stall_cycles <= 0;
        else
        begin
            stall_cycles <= stall_cycles + 1;
            if (stall_cycles == STALL_LIMIT)
            begin
                $display("timeout: no progress for %0d cycles", STALL_LIMIT);
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    initial
    begin
        for (int i = 0; i < MAX_NODES; i++)
        begin
            tree_depth[i]  = '0;
            tree_parent[i] = '0;
            tree_jump[i]   = '0;
            kids[i]        = 0;
        end
        stall_cycles = 0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        test_directed_basics();
        test_cycle_bound();
        test_deep_chain();
        test_random_forests();

        start <= 1'b0;
        while (pending_answers.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("checked %0d results: %0d adds, %0d lca, %0d kth (%0d past the root), %0d unused",
                 answers_checked, adds_sent, lca_sent, kth_sent, kth_too_deep, unused_sent);
        $display("deepest node at depth %0d, %0d mismatches", deepest, error_count);
        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

`default_nettype wire

[sim.f]
rtl/taje_pkg.sv
rtl/tree_ancestor_jump_engine.sv
rtl/taje_checker.sv
dv/tb_top.sv
